// ----- design/mctb_pkg.sv -----
package mctb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int INDEX_WIDTH = 3;
   localparam int COUNT_WIDTH = 32;
   localparam int STEP_WIDTH  = 5;

   localparam logic [COUNT_WIDTH-1:0] TENTHS_FACTOR  = 32'd100;
   localparam logic [COUNT_WIDTH-1:0] SECONDS_FACTOR = TENTHS_FACTOR * 32'd10;
   localparam logic [COUNT_WIDTH-1:0] MINUTES_FACTOR = SECONDS_FACTOR * 32'd60;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_START   = 3'd1,
      OP_SET     = 3'd2,
      OP_GET     = 3'd3,
      OP_PAUSE   = 3'd4,
      OP_STOP    = 3'd5,
      OP_STOPALL = 3'd6,
      OP_SERVICE = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      UNIT_MS      = 2'd0,
      UNIT_TENTHS  = 2'd1,
      UNIT_SECONDS = 2'd2,
      UNIT_MINUTES = 2'd3
   } unit_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_SERVICE,
      ST_MUL,
      ST_WRITE,
      ST_DIV,
      ST_RESP
   } state_type;

   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   function automatic logic [COUNT_WIDTH-1:0] unit_factor(input logic [1:0] code);
      logic [COUNT_WIDTH-1:0] f;
      unique case (unit_type'(code))
         UNIT_MS:      f = 32'd1;
         UNIT_TENTHS:  f = TENTHS_FACTOR;
         UNIT_SECONDS: f = SECONDS_FACTOR;
         UNIT_MINUTES: f = MINUTES_FACTOR;
      endcase
      return f;
   endfunction

endpackage

// ----- design/multi_countdown_timer_bank_top.sv -----
// Tick and service: busy while the walk visits one timer per cycle; tick decrements go
// through the shared subtractor, and service reports appear at most one per cycle, in the
// cycle after the walk visits the flagged timer. Start and set: busy through a multiply
// state and a write-back state. Get: busy through 32 restoring divide steps and an answer
// state; the answer strobes in the cycle after that. Pause, stop and stop all complete at acceptance.
// Synchronous reset clears every count, flag and unit; results cannot be stalled.
module multi_countdown_timer_bank_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [2:0]                          req_opcode,
   input  logic [mctb_pkg::INDEX_WIDTH-1:0]    req_timer_index,
   input  logic [mctb_pkg::COUNT_WIDTH-1:0]    req_duration,
   input  logic [1:0]                          req_unit_code,
   input  logic                                req_hold,
   output logic                                rsp_valid,
   output logic                                rsp_result_kind,
   output logic [mctb_pkg::INDEX_WIDTH-1:0]    rsp_result_timer,
   output logic [mctb_pkg::COUNT_WIDTH-1:0]    rsp_result_value,
   output logic                                rsp_last_result
);

   localparam int N = mctb_pkg::TIMER_COUNT;
   localparam int W = mctb_pkg::COUNT_WIDTH;
   localparam int IW = mctb_pkg::INDEX_WIDTH;

   mctb_pkg::state_type  state_ff, state_in;
   mctb_pkg::opcode_type op_ff, op_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [W-1:0]         dur_ff, dur_in;
   logic [1:0]           unit_cmd_ff, unit_cmd_in;

   logic [W-1:0]         count_ff [N];
   logic [W-1:0]         count_in [N];
   logic [1:0]           unit_ff [N];
   logic [1:0]           unit_in [N];
   logic [N-1:0]         expired_ff, expired_in;
   logic [N-1:0]         paused_ff, paused_in;

   logic [IW-1:0]        walk_ff, walk_in;
   logic [mctb_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic [W-1:0]         prod_ff, prod_in;
   logic [W-1:0]         rem_ff, rem_in;
   logic [W-1:0]         quo_ff, quo_in;
   logic [W-1:0]         divisor_ff, divisor_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [IW-1:0]        rsp_timer_ff, rsp_timer_in;
   logic [W-1:0]         rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Shared subtractor: decrement during a tick walk, trial subtraction during a divide.
   logic [W-1:0]         sub_a, sub_b;
   logic [W:0]           sub_diff;
   logic                 sub_borrow;
   logic [W-1:0]         mul_factor;
   logic [W-1:0]         mul_product;
   logic                 req_valid_idx;
   logic [N-1:0]         higher_flags;

   assign req_valid_idx = ({1'b0, req_timer_index} < (IW+1)'(N));

   always_comb begin
      if (state_ff == mctb_pkg::ST_DIV) begin
         sub_a = {rem_ff[W-2:0], quo_ff[W-1]};
         sub_b = divisor_ff;
      end else begin
         sub_a = count_ff[walk_ff];
         sub_b = W'(1);
      end
   end

   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[W];

   assign mul_factor  = (op_ff == mctb_pkg::OP_START) ? mctb_pkg::unit_factor(unit_cmd_ff)
                                                      : mctb_pkg::unit_factor(unit_ff[idx_ff]);
   assign mul_product = dur_ff * mul_factor;

   assign higher_flags = (expired_ff >> walk_ff) >> 1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      dur_in       = dur_ff;
      unit_cmd_in  = unit_cmd_ff;
      count_in     = count_ff;
      unit_in      = unit_ff;
      expired_in   = expired_ff;
      paused_in    = paused_ff;
      walk_in      = walk_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_timer_in = rsp_timer_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         mctb_pkg::ST_IDLE: begin
            if (start) begin
               op_in       = mctb_pkg::opcode_type'(req_opcode);
               idx_in      = req_timer_index;
               dur_in      = req_duration;
               unit_cmd_in = req_unit_code;
               walk_in     = '0;
               unique case (mctb_pkg::opcode_type'(req_opcode))
                  mctb_pkg::OP_TICK:    state_in = mctb_pkg::ST_TICK;
                  mctb_pkg::OP_SERVICE: state_in = mctb_pkg::ST_SERVICE;
                  mctb_pkg::OP_START,
                  mctb_pkg::OP_SET: begin
                     if (req_valid_idx) state_in = mctb_pkg::ST_MUL;
                  end
                  mctb_pkg::OP_GET: begin
                     if (req_valid_idx) begin
                        rem_in     = '0;
                        quo_in     = count_ff[req_timer_index];
                        divisor_in = mctb_pkg::unit_factor(unit_ff[req_timer_index]);
                        step_in    = '0;
                        state_in   = mctb_pkg::ST_DIV;
                     end else begin
                        // A timer outside the bank reads as zero straight away.
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = mctb_pkg::KIND_VALUE;
                        rsp_timer_in = req_timer_index;
                        rsp_value_in = '0;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  mctb_pkg::OP_PAUSE: begin
                     if (req_valid_idx) paused_in[req_timer_index] = req_hold;
                  end
                  mctb_pkg::OP_STOP: begin
                     if (req_valid_idx) begin
                        count_in[req_timer_index]   = '0;
                        unit_in[req_timer_index]    = '0;
                        expired_in[req_timer_index] = 1'b0;
                        paused_in[req_timer_index]  = 1'b0;
                     end
                  end
                  mctb_pkg::OP_STOPALL: begin
                     for (int t = 0; t < N; t++) begin
                        count_in[t] = '0;
                        unit_in[t]  = '0;
                     end
                     expired_in = '0;
                     paused_in  = '0;
                  end
               endcase
            end
         end

         mctb_pkg::ST_TICK: begin
            if ((count_ff[walk_ff] != '0) && !paused_ff[walk_ff]) begin
               count_in[walk_ff] = sub_diff[W-1:0];
               if (sub_diff[W-1:0] == '0) expired_in[walk_ff] = 1'b1;
            end
            walk_in = walk_ff + 1'b1;
            if (walk_ff == IW'(N-1)) state_in = mctb_pkg::ST_IDLE;
         end

         mctb_pkg::ST_SERVICE: begin
            if (expired_ff[walk_ff]) begin
               expired_in[walk_ff] = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = mctb_pkg::KIND_REPORT;
               rsp_timer_in = walk_ff;
               rsp_value_in = '0;
               // The last report is the one with no flagged timer above it.
               rsp_last_in  = (higher_flags == '0);
            end
            walk_in = walk_ff + 1'b1;
            if (walk_ff == IW'(N-1)) state_in = mctb_pkg::ST_IDLE;
         end

         mctb_pkg::ST_MUL: begin
            prod_in  = mul_product;
            state_in = mctb_pkg::ST_WRITE;
         end

         mctb_pkg::ST_WRITE: begin
            count_in[idx_ff] = prod_ff;
            if (op_ff == mctb_pkg::OP_START) begin
               unit_in[idx_ff]    = unit_cmd_ff;
               expired_in[idx_ff] = (prod_ff == '0);
            end
            state_in = mctb_pkg::ST_IDLE;
         end

         mctb_pkg::ST_DIV: begin
            rem_in  = sub_borrow ? sub_a : sub_diff[W-1:0];
            quo_in  = {quo_ff[W-2:0], !sub_borrow};
            step_in = step_ff + 1'b1;
            if (step_ff == mctb_pkg::STEP_WIDTH'(W-1)) state_in = mctb_pkg::ST_RESP;
         end

         mctb_pkg::ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = mctb_pkg::KIND_VALUE;
            rsp_timer_in = idx_ff;
            rsp_value_in = quo_ff;
            rsp_last_in  = 1'b1;
            state_in     = mctb_pkg::ST_IDLE;
         end

         default: state_in = mctb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mctb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         expired_ff   <= '0;
         paused_ff    <= '0;
         for (int t = 0; t < N; t++) begin
            count_ff[t] <= '0;
            unit_ff[t]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         expired_ff   <= expired_in;
         paused_ff    <= paused_in;
         count_ff     <= count_in;
         unit_ff      <= unit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      dur_ff       <= dur_in;
      unit_cmd_ff  <= unit_cmd_in;
      walk_ff      <= walk_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      divisor_ff   <= divisor_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_timer_ff <= rsp_timer_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy             = (state_ff != mctb_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_timer = rsp_timer_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last_result  = rsp_last_ff;

   a_tick_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == mctb_pkg::OP_TICK)) |=> busy)
      else $error("tick command did not start a walk");

   a_value_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == mctb_pkg::KIND_VALUE)) |-> rsp_last_result)
      else $error("read answer not marked as final word");

   a_report_clears_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == mctb_pkg::KIND_REPORT)) |->
         !expired_ff[rsp_result_timer])
      else $error("reported timer still flagged");

   a_quiet_during_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mctb_pkg::ST_TICK) |-> !rsp_valid)
      else $error("result word during a tick walk");

endmodule
